// ===== sv/slifo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slifo_pkg
// Shared types and codes for the searchable stack: request and response
// payloads, opcodes, status codes and the internal command word.
// ----------------------------------------------------------------------------
package slifo_pkg;

   typedef enum logic [2:0] {
      OP_PUSH    = 3'd0,
      OP_POP     = 3'd1,
      OP_DISPLAY = 3'd2,
      OP_SEARCH  = 3'd3,
      OP_UPDATE  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic [2:0]         position;
      logic               last;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
   } cmd_type;

endpackage

// ===== sv/slifo_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slifo_front
// Request intake: decodes the opcode, drops unused opcodes and hands
// valid commands to the command queue.
// ----------------------------------------------------------------------------
module slifo_front
   import slifo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic op_known;

   always_comb begin
      op_known = req_payload.op inside {OP_PUSH, OP_POP, OP_DISPLAY, OP_SEARCH, OP_UPDATE};
      req_stall = q_full;
      q_push = req_valid && !q_full && op_known;
      q_cmd.op = op_type'(req_payload.op);
      q_cmd.value = req_payload.value;
      q_cmd.new_value = req_payload.new_value;
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("command pushed into a full queue");
   a_unused_op_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_payload.op > 3'd4) |-> !q_push)
      else $error("unused opcode forwarded");
   a_known_op_forwarded: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && op_known) |-> q_push)
      else $error("accepted request lost");
`endif

endmodule

// ===== sv/slifo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slifo_queue
// Two-entry command queue between intake and execution.
// ----------------------------------------------------------------------------
module slifo_queue
   import slifo_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    q_valid,
   input  logic    take,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full = (count_ff == 2'd2);
      q_valid = (count_ff != 2'd0);
      head_cmd = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !q_valid |-> !take)
      else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");
`endif

endmodule

// ===== sv/slifo_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slifo_back
// Execution engine: holds the entry memory and fill count, runs push and
// pop, scans top to bottom for display, search and update, and drives the
// response register.
// ----------------------------------------------------------------------------
module slifo_back
   import slifo_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_take,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pend_pos_ff, pend_pos_in;
   cmd_type            cmd_ff, cmd_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic signed [31:0] entries_ff [DEPTH];
   logic signed [31:0] rd_data_ff;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   logic               load_ok;
   logic               emit;
   rsp_type            emit_rsp;
   logic               is_empty;
   logic               is_full;
   logic               matched;
   logic [IW-1:0]      top_idx;

   always_comb begin
      load_ok = !rsp_valid_ff || !rsp_stall;
      is_empty = (count_ff == '0);
      is_full = (count_ff == CW'(DEPTH));
      top_idx = IW'(count_ff - CW'(1));
      matched = (rd_data_ff == cmd_ff.value);

      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pend_in = pend_ff;
      pend_pos_in = pend_pos_ff;
      cmd_in = cmd_ff;
      q_take = 1'b0;
      emit = 1'b0;
      emit_rsp = '0;
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = cmd_ff.new_value;
      rd_addr = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (q_valid && load_ok) begin
               q_take = 1'b1;
               cmd_in = q_cmd;
               pend_in = 1'b0;
               case (q_cmd.op)
                  OP_PUSH: begin
                     emit = 1'b1;
                     emit_rsp.last = 1'b1;
                     if (is_full) begin
                        emit_rsp.status = STATUS_FULL;
                     end else begin
                        emit_rsp.status = STATUS_OK;
                        wr_en = 1'b1;
                        wr_addr = IW'(count_ff);
                        wr_data = q_cmd.value;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        emit = 1'b1;
                        emit_rsp.status = STATUS_EMPTY;
                        emit_rsp.last = 1'b1;
                     end else begin
                        count_in = count_ff - CW'(1);
                        idx_in = top_idx;
                        rd_addr = top_idx;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     if (is_empty) begin
                        emit = 1'b1;
                        emit_rsp.status = STATUS_EMPTY;
                        emit_rsp.last = 1'b1;
                     end else begin
                        idx_in = top_idx;
                        rd_addr = top_idx;
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            if (load_ok) begin
               emit = 1'b1;
               emit_rsp.status = STATUS_OK;
               emit_rsp.data = rd_data_ff;
               emit_rsp.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (load_ok) begin
               case (cmd_ff.op)
                  OP_DISPLAY: begin
                     emit = 1'b1;
                     emit_rsp.status = STATUS_OK;
                     emit_rsp.data = rd_data_ff;
                     emit_rsp.position = 3'(idx_ff);
                     emit_rsp.last = (idx_ff == '0);
                     if (idx_ff == '0) begin
                        state_in = S_IDLE;
                     end else begin
                        idx_in = idx_ff - IW'(1);
                        rd_addr = idx_ff - IW'(1);
                     end
                  end
                  OP_SEARCH: begin
                     if (matched) begin
                        if (pend_ff) begin
                           emit = 1'b1;
                           emit_rsp.status = STATUS_OK;
                           emit_rsp.position = 3'(pend_pos_ff);
                        end
                        pend_in = 1'b1;
                        pend_pos_in = idx_ff;
                     end
                     if (idx_ff == '0) begin
                        state_in = S_FINISH;
                     end else begin
                        idx_in = idx_ff - IW'(1);
                        rd_addr = idx_ff - IW'(1);
                     end
                  end
                  default: begin
                     if (matched) begin
                        wr_en = 1'b1;
                        wr_addr = idx_ff;
                        emit = 1'b1;
                        emit_rsp.status = STATUS_OK;
                        emit_rsp.position = 3'(idx_ff);
                        emit_rsp.last = 1'b1;
                        state_in = S_IDLE;
                     end else if (idx_ff == '0) begin
                        emit = 1'b1;
                        emit_rsp.status = STATUS_NOTFOUND;
                        emit_rsp.last = 1'b1;
                        state_in = S_IDLE;
                     end else begin
                        idx_in = idx_ff - IW'(1);
                        rd_addr = idx_ff - IW'(1);
                     end
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (load_ok) begin
               emit = 1'b1;
               emit_rsp.last = 1'b1;
               if (pend_ff) begin
                  emit_rsp.status = STATUS_OK;
                  emit_rsp.position = 3'(pend_pos_ff);
               end else begin
                  emit_rsp.status = STATUS_NOTFOUND;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in = emit_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      pend_pos_ff <= pend_pos_in;
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count beyond depth");
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (CW'(idx_ff) < count_ff))
      else $error("scan index outside stored entries");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (q_take && q_cmd.op == OP_PUSH && !is_full) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not grow the stack");
   a_finish_only_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (cmd_ff.op == OP_SEARCH))
      else $error("finish state outside search");
   a_no_emit_over_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !emit)
      else $error("response overwritten while held");
`endif

endmodule

// ===== sv/searchable_lifo_stack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_lifo_stack
// Stack of DEPTH signed words with push, pop, display, search and update.
//
// Requests enter on req_valid/req_stall with a req_type payload; responses
// leave on rsp_valid/rsp_stall with an rsp_type payload, last marking the
// final response of a request. Unused opcodes are dropped with no response.
// Intake feeds a two-entry command queue; the execution engine takes one
// command at a time from it.
// Push responds straight from the idle state; pop reads the top entry
// through the registered memory read port and responds from its pop state.
// Display, search and update scan one stored entry per cycle through that
// port unless the response stalls, one response per cycle for display;
// search delivers its final match from a finish state after the scan ends.
// Reset empties the stack and the queue; entry contents are not cleared.
// A stalled response holds in the output register; the engine waits, the
// queue fills and req_stall rises once both queue entries are taken.
// ----------------------------------------------------------------------------
module searchable_lifo_stack
   import slifo_pkg::*;
#(
   parameter int DEPTH = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    q_full;
   logic    q_push;
   cmd_type q_in_cmd;
   logic    q_valid;
   logic    q_take;
   cmd_type q_head_cmd;

   slifo_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_in_cmd)
   );

   slifo_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .full     (q_full),
      .q_valid  (q_valid),
      .take     (q_take),
      .head_cmd (q_head_cmd)
   );

   slifo_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_head_cmd),
      .q_take      (q_take),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the searchable stack. A short directed table covers
// the empty and full stack, word extremes, every opcode and the unused ones;
// a random phase then alternates filling and draining stretches, drawing
// search and update keys mostly from stored words so that matches, repeated
// matches and replacements are common. Every response is checked field by
// field against an in-bench stack predictor or a directed row's status,
// with random gaps on the request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_top;
   import slifo_pkg::*;

   localparam int DEPTH       = 8;
   localparam int NUM_ROWS    = 25;
   localparam int NUM_RANDOM  = 150;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [2:0] OP_UNUSED_5 = 3'd5;
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] value;
      logic [31:0] new_value;
      logic        typed;
      logic [1:0]  status;
   } row_type;

   localparam row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{OP_POP,      32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_EMPTY},
      '{OP_DISPLAY,  32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_EMPTY},
      '{OP_SEARCH,   32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_EMPTY},
      '{OP_UPDATE,   32'h0000_0000, 32'hffff_ffff, 1'b1, STATUS_EMPTY},
      '{OP_UNUSED_5, 32'h1234_5678, 32'h0000_0000, 1'b0, STATUS_OK},
      '{OP_PUSH,     32'h8000_0000, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'h7fff_ffff, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'hffff_ffff, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'h7fff_ffff, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'h5a5a_5a5a, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'ha5a5_a5a5, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'h8000_0000, 32'h0000_0000, 1'b1, STATUS_OK},
      '{OP_PUSH,     32'h0000_0001, 32'h0000_0000, 1'b1, STATUS_FULL},
      '{OP_UNUSED_7, 32'hffff_ffff, 32'hffff_ffff, 1'b0, STATUS_OK},
      '{OP_DISPLAY,  32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK},
      '{OP_SEARCH,   32'h7fff_ffff, 32'h0000_0000, 1'b0, STATUS_OK},
      '{OP_SEARCH,   32'h8000_0000, 32'h0000_0000, 1'b0, STATUS_OK},
      '{OP_SEARCH,   32'h0000_0001, 32'h0000_0000, 1'b1, STATUS_NOTFOUND},
      '{OP_UPDATE,   32'h7fff_ffff, 32'h8000_0000, 1'b0, STATUS_OK},
      '{OP_UPDATE,   32'h0000_0001, 32'h0000_0000, 1'b1, STATUS_NOTFOUND},
      '{OP_UNUSED_6, 32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK},
      '{OP_POP,      32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK},
      '{OP_DISPLAY,  32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK},
      '{OP_SEARCH,   32'h8000_0000, 32'h0000_0000, 1'b0, STATUS_OK}
   };

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   logic signed [31:0] stack_words [DEPTH];
   int                 stack_fill;
   rsp_type            step_rsps [$];
   rsp_type            expected_rsps [$];

   int error_count  = 0;
   int request_no   = 0;
   int rsp_count    = 0;
   int rsp_seen     = 0;
   int stall_left   = 0;
   int cycle_count  = 0;

   searchable_lifo_stack #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stack predictor: applies one request, leaves its responses in step_rsps
   function automatic void apply_stack_op(input req_type r);
      rsp_type res;
      int      top_hit;
      step_rsps.delete();
      res      = '0;
      res.last = 1'b1;
      top_hit  = -1;
      if (r.op > OP_UPDATE) begin
         return;
      end
      if (r.op != OP_PUSH && stack_fill == 0) begin
         res.status = STATUS_EMPTY;
         step_rsps.push_back(res);
         return;
      end
      case (r.op)
         OP_PUSH: begin
            if (stack_fill == DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               stack_words[stack_fill] = r.value;
               stack_fill++;
            end
            step_rsps.push_back(res);
         end
         OP_POP: begin
            stack_fill--;
            res.data = stack_words[stack_fill];
            step_rsps.push_back(res);
         end
         OP_DISPLAY: begin
            for (int i = stack_fill - 1; i >= 0; i--) begin
               res.data     = stack_words[i];
               res.position = 3'(i);
               res.last     = (i == 0);
               step_rsps.push_back(res);
            end
         end
         OP_SEARCH: begin
            res.last = 1'b0;
            for (int i = stack_fill - 1; i >= 0; i--) begin
               if (stack_words[i] == r.value) begin
                  res.position = 3'(i);
                  step_rsps.push_back(res);
               end
            end
            if (step_rsps.size() == 0) begin
               res          = '0;
               res.status   = STATUS_NOTFOUND;
               res.last     = 1'b1;
               step_rsps.push_back(res);
            end else begin
               res      = step_rsps.pop_back();
               res.last = 1'b1;
               step_rsps.push_back(res);
            end
         end
         default: begin
            for (int i = stack_fill - 1; i >= 0; i--) begin
               if (top_hit < 0 && stack_words[i] == r.value) begin
                  top_hit = i;
               end
            end
            if (top_hit < 0) begin
               res.status = STATUS_NOTFOUND;
            end else begin
               stack_words[top_hit] = r.new_value;
               res.position         = 3'(top_hit);
            end
            step_rsps.push_back(res);
         end
      endcase
   endfunction

   function automatic logic [31:0] draw_word();
      logic [31:0] pool [5];
      pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0011};
      if ($urandom_range(9) < 4) begin
         return pool[$urandom_range(4)];
      end
      return $urandom;
   endfunction

   function automatic req_type draw_request(input bit filling);
      req_type r;
      int      pick;
      pick        = $urandom_range(99);
      r.value     = draw_word();
      r.new_value = draw_word();
      if (pick < 5) begin
         r.op = 3'($urandom_range(OP_UNUSED_7, OP_UNUSED_5));
      end else if (pick < (filling ? 45 : 20)) begin
         r.op = OP_PUSH;
      end else if (pick < 55) begin
         r.op = OP_POP;
      end else if (pick < 65) begin
         r.op = OP_DISPLAY;
      end else if (pick < 87) begin
         r.op = OP_SEARCH;
      end else begin
         r.op = OP_UPDATE;
      end
      if ((r.op == OP_SEARCH || r.op == OP_UPDATE) && stack_fill > 0
          && $urandom_range(3) != 0) begin
         r.value = stack_words[$urandom_range(stack_fill - 1)];
      end
      return r;
   endfunction

   task automatic send_request(input req_type r, input logic typed,
                               input logic [1:0] typed_status);
      rsp_type want;
      int      gap;
      gap = (request_no % 32 < 8) ? 0 : $urandom_range(7);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      apply_stack_op(r);
      if (typed) begin
         want        = '0;
         want.status = typed_status;
         want.last   = 1'b1;
         expected_rsps.push_back(want);
      end else begin
         foreach (step_rsps[i]) expected_rsps.push_back(step_rsps[i]);
      end
      request_no++;
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // response checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, rsp_payload);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_payload.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_payload.status);
               error_count++;
            end
            if (rsp_payload.data !== want.data) begin
               $display("%0t: data mismatch, expected %0d, actual %0d",
                        $time, want.data, rsp_payload.data);
               error_count++;
            end
            if (rsp_payload.position !== want.position) begin
               $display("%0t: position mismatch, expected %0d, actual %0d",
                        $time, want.position, rsp_payload.position);
               error_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $display("%0t: last mismatch, expected %0d, actual %0d",
                        $time, want.last, rsp_payload.last);
               error_count++;
            end
         end
      end
   end

   // response side stalls, with quiet stretches
   always @(negedge clock) begin
      if (rsp_count != rsp_seen) begin
         rsp_seen   = rsp_count;
         stall_left = (rsp_seen % 40 < 12) ? 0 : $urandom_range(7);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      counted;
      bit      filling;
      bit      paused;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      stack_fill  = 0;
      counted     = 0;
      filling     = 1'b1;
      paused      = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_ROWS; k++) begin
         r.op        = DIRECTED_ROWS[k].op;
         r.value     = DIRECTED_ROWS[k].value;
         r.new_value = DIRECTED_ROWS[k].new_value;
         send_request(r, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].status);
      end
      drain_responses();

      while (counted < NUM_RANDOM) begin
         if (counted % 24 == 23) begin
            filling = !filling;
         end
         if (counted == NUM_RANDOM / 2 && !paused) begin
            paused = 1'b1;
            drain_responses();
         end
         r = draw_request(filling);
         send_request(r, 1'b0, STATUS_OK);
         if (r.op <= OP_UPDATE) begin
            counted++;
         end
      end

      drain_responses();
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== searchable_lifo_stack.f =====
sv/slifo_pkg.sv
sv/slifo_front.sv
sv/slifo_queue.sv
sv/slifo_back.sv
sv/searchable_lifo_stack.sv
sim/tb_top.sv
